// File: rtl/core/ctc_pkg.sv
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared types and constants of the four-channel counter/timer.
// ----------------------------------------------------------------------------
`default_nettype none

package ctc_pkg;

    localparam int MAX_CHANNELS = 4;
    localparam int CHANNELS_DEF = 4;

    // Command codes of an input transfer.
    typedef enum logic [2:0] {
        CMD_READ    = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_TRIGGER = 3'd2,
        CMD_TICK    = 3'd3,
        CMD_ACK     = 3'd4,
        CMD_RETI    = 3'd5
    } cmd_t;

    // Mode register bit positions.
    localparam int MODE_CONTROL   = 0;
    localparam int MODE_RESET     = 1;
    localparam int MODE_CONSTANT  = 2;
    localparam int MODE_TRIGSTART = 3;
    localparam int MODE_RISING    = 4;
    localparam int MODE_PRE256    = 5;
    localparam int MODE_COUNTER   = 6;
    localparam int MODE_INTEN     = 7;
    localparam int MODE_WAITING   = 8;

    localparam logic [8:0] CONST_256   = 9'h100;
    localparam logic [9:0] STEP_16     = 10'd16;
    localparam logic [9:0] STEP_256    = 10'd256;
    localparam logic [7:0] VECTOR_MASK = 8'hf8;

    // Control from the top level to one channel for the current transfer.
    typedef struct packed {
        logic       accept;
        cmd_t       cmd;
        logic       sel;
        logic [7:0] data;
        logic       level;
        logic [3:0] cycles;
        logic       grant;
        logic       reti_clr;
    } chan_ctl_t;

    // Status from one channel back to the top level.
    typedef struct packed {
        logic       pend;
        logic       insvc;
        logic       pend_next;
        logic       insvc_next;
        logic [7:0] count_low;
        logic       zero;
    } chan_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/four_channel_counter_timer_daisy_irq_unit.sv
// Result: the m_ side shows a transfer's result from the cycle after it is accepted.
// Throughput: one item per cycle while the consumer takes results (m_ready);
// the only register between the channels and the result port is the single
// result register, which is refilled in the same cycle it is drained.
// Reset: synchronous, active low on aresetn; clears every channel, the vector
// base, the interrupt line and the result register.
// ----------------------------------------------------------------------------
// four_channel_counter_timer_daisy_irq_unit
// Four-channel counter/timer with a daisy-chained interrupt, top level.
// ----------------------------------------------------------------------------
`default_nettype none

module four_channel_counter_timer_daisy_irq_unit #(
    parameter int CHANNELS = ctc_pkg::CHANNELS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [2:0] s_command,
    input  wire logic [1:0] s_channel,
    input  wire logic [7:0] s_data,
    input  wire logic       s_level,
    input  wire logic [3:0] s_cycles,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_read_data,
    output logic            m_int_request,
    output logic [3:0]      m_zero_count_mask
);

    localparam int MAXC = ctc_pkg::MAX_CHANNELS;

    // Result register and interrupt vector base.
    logic       m_valid_reg;
    logic [7:0] m_read_data_reg, m_read_data_next;
    logic       m_int_request_reg, m_int_request_next;
    logic [3:0] m_zero_count_mask_reg, m_zero_count_mask_next;
    logic [7:0] vector_base_reg, vector_base_next;

    // Shadow of channel 0's constant-follows flag, kept so that the vector
    // decode below does not reach into the channel.
    logic       const0_reg, const0_next;

    logic                accept;
    ctc_pkg::cmd_t       cmd;
    logic                chan_ok;
    logic [MAXC-1:0]     grant_vec;
    logic [MAXC-1:0]     reti_vec;
    logic [MAXC-1:0]     pend_vec;
    logic [MAXC-1:0]     zero_vec;
    logic                ack_hit;
    logic [1:0]          ack_idx;
    ctc_pkg::chan_ctl_t  ctl [MAXC];
    ctc_pkg::chan_stat_t stat [MAXC];

    // A new transfer is taken whenever the result register is empty or is
    // being emptied in this same cycle, so the two sides never wait on
    // each other beyond the consumer's own back-pressure.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign cmd     = ctc_pkg::cmd_t'(s_command);

    // Channel numbers at or above the configured count are not present:
    // reads return zero, writes and triggers are dropped.
    assign chan_ok = ({1'b0, s_channel} < 3'(CHANNELS));

    // Daisy chain.  The acknowledge goes to the first pending channel in
    // priority order (channel 0 first), but a channel in service blocks itself
    // and every higher-numbered channel.  A return from interrupt clears the
    // lowest-numbered channel that is in service.
    always_comb begin
        logic blocked;
        logic done;
        grant_vec = '0;
        reti_vec  = '0;
        ack_hit   = 1'b0;
        ack_idx   = '0;
        blocked   = 1'b0;
        done      = 1'b0;
        for (int i = 0; i < MAXC; i++) begin
            if (!blocked && !ack_hit) begin
                if (stat[i].insvc) begin
                    blocked = 1'b1;
                end else if (stat[i].pend) begin
                    grant_vec[i] = 1'b1;
                    ack_hit      = 1'b1;
                    ack_idx      = 2'(i);
                end
            end
            if (!done && stat[i].insvc) begin
                reti_vec[i] = 1'b1;
                done        = 1'b1;
            end
        end
    end

    // Channel instances; missing channels report an idle status.
    for (genvar g = 0; g < MAXC; g++) begin : g_chan
        assign ctl[g].accept   = accept;
        assign ctl[g].cmd      = cmd;
        assign ctl[g].sel      = chan_ok && (s_channel == 2'(g));
        assign ctl[g].data     = s_data;
        assign ctl[g].level    = s_level;
        assign ctl[g].cycles   = s_cycles;
        assign ctl[g].grant    = grant_vec[g];
        assign ctl[g].reti_clr = reti_vec[g];
        if (g < CHANNELS) begin : g_on
            ctc_chan u_chan (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (ctl[g]),
                .stat    (stat[g])
            );
        end else begin : g_off
            assign stat[g] = '0;
        end
        assign pend_vec[g] = stat[g].pend;
        assign zero_vec[g] = stat[g].zero;
    end

    // Result of the current transfer and the interrupt line it leaves behind.
    always_comb begin
        logic stop;
        vector_base_next       = vector_base_reg;
        m_read_data_next       = '0;
        m_zero_count_mask_next = '0;
        case (cmd)
            ctc_pkg::CMD_READ: begin
                if (chan_ok) begin
                    m_read_data_next = stat[s_channel].count_low;
                end
            end
            ctc_pkg::CMD_WRITE: begin
                // A byte with bit 0 clear on channel 0 is the vector base,
                // unless that channel is waiting for its time constant.
                if (chan_ok && (s_channel == 2'd0) &&
                    !s_data[ctc_pkg::MODE_CONTROL] && !const0_reg) begin
                    vector_base_next = s_data & ctc_pkg::VECTOR_MASK;
                end
            end
            ctc_pkg::CMD_TRIGGER: begin
                m_zero_count_mask_next = zero_vec;
            end
            ctc_pkg::CMD_TICK: begin
                m_zero_count_mask_next = zero_vec;
            end
            ctc_pkg::CMD_ACK: begin
                m_read_data_next = ack_hit ? (vector_base_reg | {5'd0, ack_idx, 1'b0})
                                           : vector_base_reg;
            end
            default: begin
            end
        endcase

        m_int_request_next = 1'b0;
        stop               = 1'b0;
        for (int i = 0; i < MAXC; i++) begin
            if (!stop) begin
                if (stat[i].insvc_next) begin
                    stop = 1'b1;
                end else if (stat[i].pend_next) begin
                    m_int_request_next = 1'b1;
                    stop               = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg           <= 1'b0;
            m_read_data_reg       <= '0;
            m_int_request_reg     <= 1'b0;
            m_zero_count_mask_reg <= '0;
            vector_base_reg       <= '0;
        end else begin
            if (accept) begin
                m_valid_reg           <= 1'b1;
                m_read_data_reg       <= m_read_data_next;
                m_int_request_reg     <= m_int_request_next;
                m_zero_count_mask_reg <= m_zero_count_mask_next;
                vector_base_reg       <= vector_base_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_read_data       = m_read_data_reg;
    assign m_int_request     = m_int_request_reg;
    assign m_zero_count_mask = m_zero_count_mask_reg;

    // Channel 0 swallows the next byte as its time constant after a control
    // word with the constant-follows bit; the shadow tracks that flag.
    always_comb begin
        const0_next = const0_reg;
        if ((cmd == ctc_pkg::CMD_WRITE) && chan_ok && (s_channel == 2'd0)) begin
            if (const0_reg) begin
                const0_next = 1'b0;
            end else if (s_data[ctc_pkg::MODE_CONTROL]) begin
                const0_next = s_data[ctc_pkg::MODE_CONSTANT];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            const0_reg <= 1'b0;
        end else if (accept) begin
            const0_reg <= const0_next;
        end
    end

    // At most one channel takes an acknowledge.
    assert property (@(posedge aclk) disable iff (!aresetn) $onehot0(grant_vec))
        else $error("more than one channel granted on acknowledge");

    // A raised interrupt line in the result always has a pending channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_int_request_reg) |-> (pend_vec != '0))
        else $error("interrupt request without a pending channel");

    // Only present channels can report reaching zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_zero_count_mask_reg >> CHANNELS) == 4'd0))
        else $error("zero count reported for an absent channel");

    // The result register is empty right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid_reg)
        else $error("result valid directly after reset");

endmodule

`default_nettype wire

// File: rtl/core/ctc_chan.sv
// ----------------------------------------------------------------------------
// ctc_chan
// One counter/timer channel: mode, time constant, down counter, prescaler,
// trigger edge detection and its interrupt flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ctc_chan (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ctc_pkg::chan_ctl_t ctl,
    output ctc_pkg::chan_stat_t     stat
);

    logic [8:0] mode_reg,  mode_next;
    logic [8:0] tc_reg,    tc_next;
    logic [8:0] count_reg, count_next;
    logic [8:0] frac_reg,  frac_next;
    logic       run_reg,   run_next;
    logic       trig_reg,  trig_next;
    logic       pend_reg,  pend_next;
    logic       insvc_reg, insvc_next;
    logic       zero;

    always_comb begin
        logic       do_dec;
        logic [8:0] dec_val;
        logic [8:0] new_tc;
        logic [9:0] frac_sum;
        logic [9:0] step;

        mode_next  = mode_reg;
        tc_next    = tc_reg;
        count_next = count_reg;
        frac_next  = frac_reg;
        run_next   = run_reg;
        trig_next  = trig_reg;
        pend_next  = pend_reg;
        insvc_next = insvc_reg;
        do_dec     = 1'b0;
        new_tc     = (ctl.data != 8'd0) ? {1'b0, ctl.data} : ctc_pkg::CONST_256;
        frac_sum   = {1'b0, frac_reg} + {6'd0, ctl.cycles};
        step       = mode_reg[ctc_pkg::MODE_PRE256] ? ctc_pkg::STEP_256 : ctc_pkg::STEP_16;

        case (ctl.cmd)
            ctc_pkg::CMD_WRITE: begin
                if (ctl.sel) begin
                    if (mode_reg[ctc_pkg::MODE_CONSTANT]) begin
                        // Time constant load after a control word asked for it.
                        tc_next    = new_tc;
                        count_next = new_tc;
                        frac_next  = '0;
                        mode_next[ctc_pkg::MODE_CONSTANT] = 1'b0;
                        mode_next[ctc_pkg::MODE_RESET]    = 1'b0;
                        if (mode_reg[ctc_pkg::MODE_COUNTER] ||
                            !mode_reg[ctc_pkg::MODE_TRIGSTART]) begin
                            run_next = 1'b1;
                        end else begin
                            mode_next[ctc_pkg::MODE_WAITING] = 1'b1;
                            run_next = 1'b0;
                        end
                    end else if (ctl.data[ctc_pkg::MODE_CONTROL]) begin
                        if (ctl.data[ctc_pkg::MODE_RESET]) begin
                            run_next = 1'b0;
                        end
                        mode_next = {1'b0, ctl.data};
                        if (!ctl.data[ctc_pkg::MODE_INTEN] && pend_reg) begin
                            pend_next  = 1'b0;
                            insvc_next = 1'b0;
                        end
                    end
                end
            end
            ctc_pkg::CMD_TRIGGER: begin
                if (ctl.sel && (ctl.level != trig_reg)) begin
                    trig_next = ctl.level;
                    if (mode_reg[ctc_pkg::MODE_RISING] == ctl.level) begin
                        if (mode_reg[ctc_pkg::MODE_WAITING] &&
                            !mode_reg[ctc_pkg::MODE_COUNTER]) begin
                            run_next  = 1'b1;
                            frac_next = '0;
                        end
                        mode_next[ctc_pkg::MODE_WAITING] = 1'b0;
                        do_dec = mode_reg[ctc_pkg::MODE_COUNTER] &&
                                 !mode_reg[ctc_pkg::MODE_RESET];
                    end
                end
            end
            ctc_pkg::CMD_TICK: begin
                if (run_reg && !mode_reg[ctc_pkg::MODE_COUNTER] &&
                    !mode_reg[ctc_pkg::MODE_RESET]) begin
                    if (frac_sum >= step) begin
                        frac_next = 9'(frac_sum - step);
                        do_dec    = 1'b1;
                    end else begin
                        frac_next = frac_sum[8:0];
                    end
                end
            end
            ctc_pkg::CMD_ACK: begin
                if (ctl.grant) begin
                    pend_next  = 1'b0;
                    insvc_next = 1'b1;
                end
            end
            ctc_pkg::CMD_RETI: begin
                if (ctl.reti_clr) begin
                    insvc_next = 1'b0;
                end
            end
            default: begin
            end
        endcase

        // A counter already at zero stays there and reloads at once.
        dec_val = (count_reg != 9'd0) ? count_reg - 9'd1 : 9'd0;
        zero    = 1'b0;
        if (do_dec) begin
            if (dec_val == 9'd0) begin
                count_next = tc_reg;
                zero       = 1'b1;
                if (mode_reg[ctc_pkg::MODE_INTEN]) begin
                    pend_next = 1'b1;
                end
            end else begin
                count_next = dec_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= '0;
            tc_reg    <= '0;
            count_reg <= '0;
            frac_reg  <= '0;
            run_reg   <= 1'b0;
            trig_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            insvc_reg <= 1'b0;
        end else if (ctl.accept) begin
            mode_reg  <= mode_next;
            tc_reg    <= tc_next;
            count_reg <= count_next;
            frac_reg  <= frac_next;
            run_reg   <= run_next;
            trig_reg  <= trig_next;
            pend_reg  <= pend_next;
            insvc_reg <= insvc_next;
        end
    end

    assign stat.pend       = pend_reg;
    assign stat.insvc      = insvc_reg;
    assign stat.pend_next  = pend_next;
    assign stat.insvc_next = insvc_next;
    assign stat.count_low  = count_reg[7:0];
    assign stat.zero       = zero;

endmodule

`default_nettype wire
